FILE: hdl/bpca_pkg.sv
package bpca_pkg;

  localparam int CELLS       = 16;
  localparam int MV_W        = 13;
  localparam int LIM_W       = 16;
  localparam int CNT_W       = $clog2(CELLS + 1);
  localparam int NUM_W       = 7;
  localparam int SUM_W       = MV_W + $clog2(CELLS);
  localparam int PACK_W      = 17;
  localparam int SOC_W       = 10;
  localparam int DIV_W       = 28;
  localparam int DIV_STEPS   = DIV_W / 2;
  localparam int DCNT_W      = $clog2(DIV_STEPS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W      = 5;
  localparam int IDX_W       = ADDR_W - 2;
  localparam int DATA_W      = 32;

  // register indexes
  localparam logic [IDX_W-1:0] REG_UNDER    = 3'd0;
  localparam logic [IDX_W-1:0] REG_OVER     = 3'd1;
  localparam logic [IDX_W-1:0] REG_FULL     = 3'd2;
  localparam logic [IDX_W-1:0] REG_HEALTHY  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MINOR    = 3'd4;
  localparam logic [IDX_W-1:0] REG_CRITICAL = 3'd5;

  localparam logic [MV_W-1:0]  UNDER_RST    = 13'd3000;
  localparam logic [MV_W-1:0]  OVER_RST     = 13'd4200;
  localparam logic [MV_W-1:0]  FULL_RST     = 13'd4200;
  localparam logic [LIM_W-1:0] HEALTHY_RST  = 16'd200;
  localparam logic [LIM_W-1:0] MINOR_RST    = 16'd500;
  localparam logic [LIM_W-1:0] CRITICAL_RST = 16'd1000;

  // cell status codes
  localparam logic [1:0] CELL_NORMAL = 2'd0;
  localparam logic [1:0] CELL_UNDER  = 2'd1;
  localparam logic [1:0] CELL_OVER   = 2'd2;

  // pack status codes
  localparam logic [1:0] PACK_HEALTHY  = 2'd0;
  localparam logic [1:0] PACK_MINOR    = 2'd1;
  localparam logic [1:0] PACK_CRITICAL = 2'd2;
  localparam logic [1:0] PACK_FAILURE  = 2'd3;

  localparam logic [31:0]      PACK_MAX  = 32'd131071;
  localparam logic [SOC_W-1:0] SOC_MAX   = 10'd1000;
  localparam logic [LIM_W-1:0] IMB_MAX   = 16'hFFFF;
  localparam logic [DIV_W-1:0] SOC_SCALE = 28'd1000;
  localparam logic [DIV_W-1:0] IMB_SCALE = 28'd10000;

  typedef struct packed {
    logic [CNT_W-1:0] num;
    logic [1:0]       status;
    logic             last;
    logic [SUM_W-1:0] sum;
    logic [MV_W-1:0]  max_mv;
    logic [CNT_W-1:0] max_idx;
    logic [MV_W-1:0]  min_mv;
    logic [CNT_W-1:0] min_idx;
  } cell_entry_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [MV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hdl/bpca_front.sv
module bpca_front
  import bpca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MV_W-1:0]   cell_mv,
  input  logic [MV_W-1:0]   under_voltage_mv,
  input  logic [MV_W-1:0]   over_voltage_mv,
  input  logic              q_full,
  output logic              push,
  output cell_entry_t       entry
);

  logic [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0] cell_counter;
  logic [MV_W-1:0]  max_value;
  logic [CNT_W-1:0] max_index;
  logic [MV_W-1:0]  min_value;
  logic [CNT_W-1:0] min_index;

  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W-1:0] num;
  logic             first;
  logic             last_cell;
  logic [1:0]       status;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cnt_eff   = (cell_counter >= CNT_W'(CELLS)) ? '0 : cell_counter;
    num       = cnt_eff + 1'b1;
    first     = (cnt_eff == '0);
    last_cell = (num == CNT_W'(CELLS));

    priority if (cell_mv < under_voltage_mv) status = CELL_UNDER;
    else if (cell_mv > over_voltage_mv)      status = CELL_OVER;
    else                                     status = CELL_NORMAL;

    entry.num    = num;
    entry.status = status;
    entry.last   = last_cell;
    entry.sum    = sum_acc + SUM_W'(cell_mv);
    if (first || cell_mv > max_value) begin
      entry.max_mv  = cell_mv;
      entry.max_idx = num;
    end else begin
      entry.max_mv  = max_value;
      entry.max_idx = max_index;
    end
    if (first || cell_mv < min_value) begin
      entry.min_mv  = cell_mv;
      entry.min_idx = num;
    end else begin
      entry.min_mv  = min_value;
      entry.min_idx = min_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc      <= '0;
      cell_counter <= '0;
      max_value    <= '0;
      max_index    <= CNT_W'(1);
      min_value    <= '0;
      min_index    <= CNT_W'(1);
    end else if (push) begin
      if (last_cell) begin
        // start a fresh pack
        sum_acc      <= '0;
        cell_counter <= '0;
        max_value    <= '0;
        max_index    <= CNT_W'(1);
        min_value    <= '0;
        min_index    <= CNT_W'(1);
      end else begin
        sum_acc      <= entry.sum;
        cell_counter <= num;
        max_value    <= entry.max_mv;
        max_index    <= entry.max_idx;
        min_value    <= entry.min_mv;
        min_index    <= entry.min_idx;
      end
    end
  end

endmodule

FILE: hdl/bpca_queue.sv
module bpca_queue
  import bpca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cell_entry_t wr_entry,
  output logic        full,
  input  logic        pop,
  output logic        rd_valid,
  output cell_entry_t head
);

  cell_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign head     = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_entry;
    end
  end

endmodule

FILE: hdl/bpca_div.sv
module bpca_div
  import bpca_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [MV_W-1:0]   rem;
  logic [DIV_W-1:0]  quo;
  logic [MV_W-1:0]   dvs;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [MV_W-1:0]   rem_next;
  logic [DIV_W-1:0]  quo_next;
  logic [MV_W:0]     trial;
  logic [MV_W:0]     diff;

  // two restoring steps per cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    diff     = '0;
    for (int k = 0; k < 2; k++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      diff     = trial - {1'b0, dvs};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = diff[MV_W-1:0];
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[MV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: hdl/bpca_back.sv
module bpca_back
  import bpca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cell_entry_t       head,
  output logic              pop,
  input  logic [MV_W-1:0]   full_scale_mv,
  input  logic [LIM_W-1:0]  healthy_bound,
  input  logic [LIM_W-1:0]  minor_bound,
  input  logic [LIM_W-1:0]  critical_bound,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NUM_W-1:0]  cell_number,
  output logic [1:0]        cell_status,
  output logic              last,
  output logic [PACK_W-1:0] pack_mv,
  output logic [MV_W-1:0]   average_mv,
  output logic [SOC_W-1:0]  charge_tenths,
  output logic [MV_W-1:0]   highest_mv,
  output logic [NUM_W-1:0]  highest_cell,
  output logic [MV_W-1:0]   lowest_mv,
  output logic [NUM_W-1:0]  lowest_cell,
  output logic [LIM_W-1:0]  imbalance_hp,
  output logic [1:0]        pack_status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SOC_GO,
    S_SOC,
    S_IMB_GO,
    S_IMB,
    S_EMIT
  } state_t;

  state_t            state;
  cell_entry_t       held;
  logic [MV_W-1:0]   avg;
  logic [SOC_W-1:0]  soc;
  logic [LIM_W-1:0]  imb;

  logic              slot_free;
  logic              emit;
  logic [MV_W-1:0]   spread;
  logic [1:0]        status_next;
  logic [PACK_W-1:0] pack_sat;
  logic [SOC_W-1:0]  soc_clamp;
  logic [LIM_W-1:0]  imb_clamp;

  assign slot_free = !out_valid || !out_stall;
  assign pop       = (state == S_IDLE) && q_valid && (head.last || slot_free);
  assign emit      = ((state == S_IDLE) && pop && !head.last) ||
                     ((state == S_EMIT) && slot_free);
  assign spread    = held.max_mv - held.min_mv;

  always_comb begin
    pack_sat  = (32'(held.sum) > PACK_MAX) ? PACK_W'(PACK_MAX) : PACK_W'(held.sum);
    soc_clamp = (div_rsp.quotient > DIV_W'(SOC_MAX)) ? SOC_MAX
                                                     : div_rsp.quotient[SOC_W-1:0];
    imb_clamp = (div_rsp.quotient > DIV_W'(IMB_MAX)) ? IMB_MAX
                                                     : div_rsp.quotient[LIM_W-1:0];

    priority if (imb < healthy_bound) status_next = PACK_HEALTHY;
    else if (imb < minor_bound)       status_next = PACK_MINOR;
    else if (imb < critical_bound)    status_next = PACK_CRITICAL;
    else                              status_next = PACK_FAILURE;

    div_req = '0;
    unique case (state)
      S_SOC_GO: begin
        if (full_scale_mv != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(avg) * SOC_SCALE;
          div_req.divisor  = full_scale_mv;
        end
      end
      S_IMB_GO: begin
        if (avg != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(spread) * IMB_SCALE;
          div_req.divisor  = avg;
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (head.last) begin
              held  <= head;
              // cell count is a power of two, so this is a shift
              avg   <= MV_W'(head.sum / SUM_W'(CELLS));
              state <= S_SOC_GO;
            end else begin
              cell_number   <= NUM_W'(head.num);
              cell_status   <= head.status;
              last          <= 1'b0;
              pack_mv       <= '0;
              average_mv    <= '0;
              charge_tenths <= '0;
              highest_mv    <= '0;
              highest_cell  <= '0;
              lowest_mv     <= '0;
              lowest_cell   <= '0;
              imbalance_hp  <= '0;
              pack_status   <= PACK_HEALTHY;
            end
          end
        end
        S_SOC_GO: begin
          if (full_scale_mv == '0) begin
            soc   <= SOC_MAX;
            state <= S_IMB_GO;
          end else begin
            state <= S_SOC;
          end
        end
        S_SOC: begin
          if (div_rsp.done) begin
            soc   <= soc_clamp;
            state <= S_IMB_GO;
          end
        end
        S_IMB_GO: begin
          if (avg == '0) begin
            imb   <= IMB_MAX;
            state <= S_EMIT;
          end else begin
            state <= S_IMB;
          end
        end
        S_IMB: begin
          if (div_rsp.done) begin
            imb   <= imb_clamp;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            cell_number   <= NUM_W'(held.num);
            cell_status   <= held.status;
            last          <= 1'b1;
            pack_mv       <= pack_sat;
            average_mv    <= avg;
            charge_tenths <= soc;
            highest_mv    <= held.max_mv;
            highest_cell  <= NUM_W'(held.max_idx);
            lowest_mv     <= held.min_mv;
            lowest_cell   <= NUM_W'(held.min_idx);
            imbalance_hp  <= imb;
            pack_status   <= status_next;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/battery_pack_cell_analyzer.sv
// For all but the last cell, a result passes through the queue slot and the output registers.
// The last cell waits on the shared divider, which resolves two quotient bits per cycle for
// the charge and the imbalance in turn; a zero full scale or zero average skips that division.
// Throughput: one cell per cycle into a 4-entry queue while the queue is not full; the
// sustained rate is bounded by the divider at the end of each pack.
// Reset: synchronous; thresholds and limits return to defaults and the pack restarts.
module battery_pack_cell_analyzer
  import bpca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MV_W-1:0]   cell_mv,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NUM_W-1:0]  cell_number,
  output logic [1:0]        cell_status,
  output logic              last,
  output logic [PACK_W-1:0] pack_mv,
  output logic [MV_W-1:0]   average_mv,
  output logic [SOC_W-1:0]  charge_tenths,
  output logic [MV_W-1:0]   highest_mv,
  output logic [NUM_W-1:0]  highest_cell,
  output logic [MV_W-1:0]   lowest_mv,
  output logic [NUM_W-1:0]  lowest_cell,
  output logic [LIM_W-1:0]  imbalance_hp,
  output logic [1:0]        pack_status
);

  logic [MV_W-1:0]  under_voltage_mv;
  logic [MV_W-1:0]  over_voltage_mv;
  logic [MV_W-1:0]  full_scale_mv;
  logic [LIM_W-1:0] healthy_bound;
  logic [LIM_W-1:0] minor_bound;
  logic [LIM_W-1:0] critical_bound;

  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  cell_entry_t      wr_entry;
  cell_entry_t      head;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      under_voltage_mv <= UNDER_RST;
      over_voltage_mv  <= OVER_RST;
      full_scale_mv    <= FULL_RST;
      healthy_bound    <= HEALTHY_RST;
      minor_bound      <= MINOR_RST;
      critical_bound   <= CRITICAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_UNDER:    under_voltage_mv <= pwdata[MV_W-1:0];
        REG_OVER:     over_voltage_mv  <= pwdata[MV_W-1:0];
        REG_FULL:     full_scale_mv    <= pwdata[MV_W-1:0];
        REG_HEALTHY:  healthy_bound    <= pwdata[LIM_W-1:0];
        REG_MINOR:    minor_bound      <= pwdata[LIM_W-1:0];
        REG_CRITICAL: critical_bound   <= pwdata[LIM_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_UNDER:    prdata = DATA_W'(under_voltage_mv);
      REG_OVER:     prdata = DATA_W'(over_voltage_mv);
      REG_FULL:     prdata = DATA_W'(full_scale_mv);
      REG_HEALTHY:  prdata = DATA_W'(healthy_bound);
      REG_MINOR:    prdata = DATA_W'(minor_bound);
      REG_CRITICAL: prdata = DATA_W'(critical_bound);
      default:      prdata = '0;
    endcase
  end

  bpca_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .cell_mv          (cell_mv),
    .under_voltage_mv (under_voltage_mv),
    .over_voltage_mv  (over_voltage_mv),
    .q_full           (q_full),
    .push             (push),
    .entry            (wr_entry)
  );

  bpca_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .head     (head)
  );

  bpca_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  bpca_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .full_scale_mv  (full_scale_mv),
    .healthy_bound  (healthy_bound),
    .minor_bound    (minor_bound),
    .critical_bound (critical_bound),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cell_number    (cell_number),
    .cell_status    (cell_status),
    .last           (last),
    .pack_mv        (pack_mv),
    .average_mv     (average_mv),
    .charge_tenths  (charge_tenths),
    .highest_mv     (highest_mv),
    .highest_cell   (highest_cell),
    .lowest_mv      (lowest_mv),
    .lowest_cell    (lowest_cell),
    .imbalance_hp   (imbalance_hp),
    .pack_status    (pack_status)
  );

  a_last_is_full_pack: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> cell_number == NUM_W'(CELLS))
    else $error("summary transaction not on the final cell of a pack");

  a_partial_has_no_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> pack_mv == '0 && imbalance_hp == '0 && highest_cell == '0)
    else $error("summary fields set on a non-final cell");

  a_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> highest_mv >= lowest_mv && charge_tenths <= SOC_MAX)
    else $error("pack extremes or charge out of range");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into full queue");

endmodule
